/* sv/mss_pkg.sv */
package mss_pkg;

  localparam int NUM_STACKS = 4;
  localparam int CAPACITY   = 64;

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int PTR_W  = $clog2(CAPACITY + 1);
  localparam int SEL_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

  localparam logic [PTR_W-1:0] PTR_NULL = PTR_W'(CAPACITY);

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_BADSTACK = 2'd3
  } status_t;

  typedef struct packed {
    op_kind_t           kind;
    logic [2:0]         stack_num;
    logic signed [31:0] push_value;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] popped_value;
  } out_item_t;

endpackage

/* sv/mss_ram.sv */
module mss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/multi_stack_shared_store.sv */
// Several LIFO stacks that share one store of slots, each slot holding a data
// word and a link to the next slot of its stack or of the free list.
// An item is taken at a rising edge where start is high and busy is low.
// It carries a push or a pop request and a stack number counted from one.
// Each item gives exactly one result on out_item, marked by out_valid for a
// single cycle; the receiver cannot stall the block and must take it then.
// A rejected item (bad stack number, full store on push, empty stack on pop)
// reports its status in the cycle after it is taken, and busy stays low,
// so such items can be given in every cycle.
// A push or pop that succeeds reads the slot's link (and for a pop its data)
// from the memories in the cycle it is taken, where a push also writes its
// word, and writes back the link in the next cycle, with busy high; its
// result is registered from that write-back cycle, and no new item is taken
// while busy is high.
// The link memory's reset chain is supplied by one valid flag per slot, so
// the block takes items as soon as reset is released, without a clearing
// pass. Reset empties all stacks and frees every slot.
module multi_stack_shared_store
  import mss_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  typedef enum logic {
    S_IDLE,
    S_WAIT
  } state_t;

  state_t              state_r, state_nxt;
  op_kind_t            op_r, op_nxt;
  logic [SEL_W-1:0]    sel_r, sel_nxt;
  logic [ADDR_W-1:0]   slot_r, slot_nxt;
  logic [PTR_W-1:0]    free_head_r, free_head_nxt;
  logic [PTR_W-1:0]    tops_r [NUM_STACKS];
  logic [PTR_W-1:0]    tops_nxt [NUM_STACKS];
  logic [CAPACITY-1:0] valid_r, valid_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_item_r, out_item_nxt;

  logic              accept;
  logic              bad_num;
  logic [SEL_W-1:0]  in_sel;
  logic [PTR_W-1:0]  cur_top;
  logic [PTR_W-1:0]  link_val;

  logic              data_we;
  logic [ADDR_W-1:0] data_waddr;
  logic [31:0]       data_wdata;
  logic              data_re;
  logic [ADDR_W-1:0] data_raddr;
  logic [31:0]       data_rdata;

  logic              link_we;
  logic [ADDR_W-1:0] link_waddr;
  logic [PTR_W-1:0]  link_wdata;
  logic              link_re;
  logic [ADDR_W-1:0] link_raddr;
  logic [PTR_W-1:0]  link_rdata;

  mss_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_data_ram (
    .clk     (clk),
    .wr_en   (data_we),
    .wr_addr (data_waddr),
    .wr_data (data_wdata),
    .rd_en   (data_re),
    .rd_addr (data_raddr),
    .rd_data (data_rdata)
  );

  mss_ram #(.WIDTH(PTR_W), .DEPTH(CAPACITY)) u_link_ram (
    .clk     (clk),
    .wr_en   (link_we),
    .wr_addr (link_waddr),
    .wr_data (link_wdata),
    .rd_en   (link_re),
    .rd_addr (link_raddr),
    .rd_data (link_rdata)
  );

  assign busy      = (state_r == S_WAIT);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign bad_num = (in_item.stack_num == 3'd0) ||
                   (32'(in_item.stack_num) > 32'(NUM_STACKS));
  assign in_sel  = SEL_W'(in_item.stack_num - 3'd1);
  assign cur_top = tops_r[in_sel];

  // A slot whose link was never written still holds its reset chain entry.
  always_comb begin
    if (valid_r[slot_r]) begin
      link_val = link_rdata;
    end else if (32'(slot_r) == CAPACITY - 1) begin
      link_val = PTR_NULL;
    end else begin
      link_val = PTR_W'(slot_r) + PTR_W'(1);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    sel_nxt       = sel_r;
    slot_nxt      = slot_r;
    free_head_nxt = free_head_r;
    tops_nxt      = tops_r;
    valid_nxt     = valid_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = '{status: ST_OK, popped_value: '0};

    data_we    = 1'b0;
    data_waddr = free_head_r[ADDR_W-1:0];
    data_wdata = in_item.push_value;
    data_re    = 1'b0;
    data_raddr = cur_top[ADDR_W-1:0];
    link_we    = 1'b0;
    link_waddr = slot_r;
    link_wdata = tops_r[sel_r];
    link_re    = 1'b0;
    link_raddr = free_head_r[ADDR_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt  = in_item.kind;
          sel_nxt = in_sel;
          if (bad_num) begin
            out_valid_nxt       = 1'b1;
            out_item_nxt.status = ST_BADSTACK;
          end else if (in_item.kind == OP_PUSH) begin
            if (free_head_r >= PTR_NULL) begin
              out_valid_nxt       = 1'b1;
              out_item_nxt.status = ST_FULL;
            end else begin
              slot_nxt   = free_head_r[ADDR_W-1:0];
              data_we    = 1'b1;
              link_re    = 1'b1;
              link_raddr = free_head_r[ADDR_W-1:0];
              state_nxt  = S_WAIT;
            end
          end else begin
            if (cur_top >= PTR_NULL) begin
              out_valid_nxt       = 1'b1;
              out_item_nxt.status = ST_EMPTY;
            end else begin
              slot_nxt   = cur_top[ADDR_W-1:0];
              data_re    = 1'b1;
              link_re    = 1'b1;
              link_raddr = cur_top[ADDR_W-1:0];
              state_nxt  = S_WAIT;
            end
          end
        end
      end
      S_WAIT: begin
        link_we           = 1'b1;
        valid_nxt[slot_r] = 1'b1;
        out_valid_nxt     = 1'b1;
        state_nxt         = S_IDLE;
        if (op_r == OP_PUSH) begin
          link_wdata       = tops_r[sel_r];
          tops_nxt[sel_r]  = PTR_W'(slot_r);
          free_head_nxt    = link_val;
        end else begin
          link_wdata                = free_head_r;
          tops_nxt[sel_r]           = link_val;
          free_head_nxt             = PTR_W'(slot_r);
          out_item_nxt.popped_value = data_rdata;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    slot_r     <= slot_nxt;
    out_item_r <= out_item_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_r       <= '0;
      free_head_r <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_STACKS; i++) begin
        tops_r[i] <= PTR_NULL;
      end
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      free_head_r <= free_head_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      tops_r      <= tops_nxt;
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start));

  a_wait_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid && !busy);

  a_bad_number_reported: assert property (@(posedge clk) disable iff (!rst_n)
    accept && bad_num |=> out_valid && out_item.status == ST_BADSTACK);

  a_failed_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != ST_OK |-> out_item.popped_value == 32'sd0);

  a_free_head_not_top: assert property (@(posedge clk) disable iff (!rst_n)
    free_head_r != PTR_NULL |-> free_head_r != tops_r[sel_r]);
`endif

endmodule
